// File: src/sacl_pkg.sv
package sacl_pkg;

  localparam int unsigned MAX_SET_BITS_DEF = 6;
  localparam int unsigned MAX_WAYS_DEF     = 8;
  localparam int unsigned ADDR_BITS_DEF    = 64;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned OUTCOME_W = 2;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned IN_ADDR_W = 64;
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_WAYS_USED  = 2'd1;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD,
    CMD_STORE,
    CMD_MODIFY,
    CMD_IFETCH
  } cmd_e;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT,
    OUT_MISS,
    OUT_EVICT
  } outcome_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOOK,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic [2:0] set_bits;
    logic [3:0] ways_used;
    logic [5:0] block_bits;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic rd;
    logic look;
    logic update;
    logic last;
  } ctl_t;

  typedef struct packed {
    logic clr_last;
    logic is_modify;
    logic out_free;
  } sts_t;

endpackage

// File: src/set_assoc_cache_lru_sim_core.sv
// Channel  Direction  Handshake                 Payload
// s_axis   in         s_axis_tvalid/tready      tuser: command, tdata: address
// m_axis   out        m_axis_tvalid/tready      tuser: outcome, tlast: last,
//                                               tdata: hit, miss, eviction totals
// apb      in         psel/penable/pwrite       set_bits, ways_used, block_bits
//
// Each access passes through set read, tag compare and row write-back once idle has
// accepted the item; a load or store makes one such pass and a modify two, each pass
// a single read-modify-write of the set RAM. After reset a clearing pass writes every
// set row with s_axis_tready low. A stalled result holds in the output register while
// the next item is accepted; an access waits in write-back until that slot is free.
module set_assoc_cache_lru_sim_core import sacl_pkg::*; #(
  parameter int unsigned MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int unsigned MAX_WAYS     = MAX_WAYS_DEF,
  parameter int unsigned ADDR_BITS    = ADDR_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_ADDR_W-1:0] s_axis_tdata,  // [63:0] address
  input  logic [CMD_W-1:0]     s_axis_tuser,  // [1:0] command
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [3*CNT_W-1:0]   m_axis_tdata,  // [31:0] hit_total, [63:32] miss_total,
                                              // [95:64] eviction_total
  output logic [OUTCOME_W-1:0] m_axis_tuser,  // [1:0] outcome
  output logic                 m_axis_tlast,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  cfg_t     cfg_q;
  ctl_t     ctl;
  sts_t     sts;
  outcome_e outcome;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.set_bits   <= 3'd0;
      cfg_q.ways_used  <= 4'd1;
      cfg_q.block_bits <= 6'd0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_SET_BITS:   cfg_q.set_bits   <= pwdata[2:0];
        REG_WAYS_USED:  cfg_q.ways_used  <= pwdata[3:0];
        REG_BLOCK_BITS: cfg_q.block_bits <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SET_BITS:   prdata = {29'd0, cfg_q.set_bits};
      REG_WAYS_USED:  prdata = {28'd0, cfg_q.ways_used};
      REG_BLOCK_BITS: prdata = {26'd0, cfg_q.block_bits};
      default:        prdata = '0;
    endcase
  end

  sacl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_cmd_i  (cmd_e'(s_axis_tuser)),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .ctl_o     (ctl)
  );

  sacl_dp #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .MAX_WAYS    (MAX_WAYS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .in_cmd_i     (cmd_e'(s_axis_tuser)),
    .in_addr_i    (s_axis_tdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_outcome_o(outcome),
    .out_last_o   (m_axis_tlast),
    .out_hits_o   (m_axis_tdata[CNT_W-1:0]),
    .out_misses_o (m_axis_tdata[2*CNT_W-1:CNT_W]),
    .out_evicts_o (m_axis_tdata[3*CNT_W-1:2*CNT_W])
  );

  assign m_axis_tuser = outcome;

endmodule

// File: src/sacl_ram.sv
module sacl_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/sacl_ctrl.sv
module sacl_ctrl import sacl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  cmd_e in_cmd_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  state_e state_q, state_d;
  logic   second_q, second_d;
  logic   accept;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && (in_cmd_i != CMD_IFETCH)) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_LOOK;
      ST_LOOK: state_d = ST_UPDATE;
      ST_UPDATE: begin
        if (sts_i.out_free) begin
          state_d = (sts_i.is_modify && !second_q) ? ST_READ : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    second_d = second_q;
    if (ctl_o.capture) begin
      second_d = 1'b0;
    end else if (ctl_o.update) begin
      second_d = 1'b1;
    end
  end

  always_comb begin
    ctl_o         = '0;
    in_ready_o    = 1'b0;
    ctl_o.last    = !(sts_i.is_modify && !second_q);
    case (state_q)
      ST_CLEAR:  ctl_o.clear = 1'b1;
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        ctl_o.capture = accept && (in_cmd_i != CMD_IFETCH);
      end
      ST_READ:   ctl_o.rd = 1'b1;
      ST_LOOK:   ctl_o.look = 1'b1;
      ST_UPDATE: ctl_o.update = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
    end
  end

endmodule

// File: src/sacl_dp.sv
module sacl_dp import sacl_pkg::*; #(
  parameter int unsigned MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int unsigned MAX_WAYS     = MAX_WAYS_DEF,
  parameter int unsigned ADDR_BITS    = ADDR_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  ctl_t                 ctl_i,
  output sts_t                 sts_o,
  input  cmd_e                 in_cmd_i,
  input  logic [IN_ADDR_W-1:0] in_addr_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output outcome_e             out_outcome_o,
  output logic                 out_last_o,
  output logic [CNT_W-1:0]     out_hits_o,
  output logic [CNT_W-1:0]     out_misses_o,
  output logic [CNT_W-1:0]     out_evicts_o
);

  localparam int unsigned NUM_SETS = 1 << MAX_SET_BITS;
  localparam int unsigned SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned AGE_W    = WAY_W;
  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);
  localparam logic [AGE_W:0]   AGE_LIM = (AGE_W + 1)'(MAX_WAYS);
  localparam logic [3:0] MSB_L = 4'(MAX_SET_BITS);
  localparam logic [4:0] MW_L  = 5'(MAX_WAYS);
  localparam logic [IN_ADDR_W-1:0] ADDR_MASK =
      (ADDR_BITS >= IN_ADDR_W) ? '1 : ((IN_ADDR_W'(1) << ADDR_BITS) - IN_ADDR_W'(1));

  typedef struct packed {
    logic [AGE_W-1:0]     age;
    logic                 vld;
    logic [ADDR_BITS-1:0] tag;
  } line_t;

  localparam int unsigned ROW_W = $bits(line_t) * MAX_WAYS;

  logic                 is_modify_q;
  logic [IN_ADDR_W-1:0] addr_q;
  logic [SET_W-1:0]     set_q, set_c, clr_idx_q;
  logic [ADDR_BITS-1:0] tag_q, tag_c;
  logic [3:0]           sb;
  logic [4:0]           ways;
  logic [IN_ADDR_W-1:0] a_m, a_sh, t_sh;
  logic [6:0]           t_amt;

  line_t [MAX_WAYS-1:0] row, new_row;
  logic [ROW_W-1:0]     rd_data;

  logic             hit_c, inv_c;
  logic [WAY_W-1:0] hit_idx_c, inv_idx_c, vic_idx_c;
  logic [AGE_W-1:0] best_age;
  logic             hit_q, inv_q;
  logic [WAY_W-1:0] hit_idx_q, inv_idx_q, vic_idx_q, w_sel;
  logic [AGE_W:0]   limit;

  logic [CNT_W-1:0] hits_q, miss_q, evict_q, hits_d, miss_d, evict_d;
  logic             out_valid_q;
  outcome_e         outcome_c, outcome_q;
  logic             last_q;

  always_comb begin
    sb    = ({1'b0, cfg_i.set_bits} > MSB_L) ? MSB_L : {1'b0, cfg_i.set_bits};
    ways  = {1'b0, cfg_i.ways_used};
    if (ways == 5'd0) begin
      ways = 5'd1;
    end else if (ways > MW_L) begin
      ways = MW_L;
    end
    a_m   = addr_q & ADDR_MASK;
    a_sh  = a_m >> cfg_i.block_bits;
    set_c = a_sh[SET_W-1:0] & ~({SET_W{1'b1}} << sb);
    t_amt = {1'b0, cfg_i.block_bits} + {3'b000, sb};
    t_sh  = a_m >> t_amt;
    tag_c = t_sh[ADDR_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      is_modify_q <= (in_cmd_i == CMD_MODIFY);
      addr_q      <= in_addr_i;
    end
    if (ctl_i.rd) begin
      set_q <= set_c;
      tag_q <= tag_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
    end else if (ctl_i.clear) begin
      clr_idx_q <= clr_idx_q + SET_W'(1);
    end
  end

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS),
    .ADDR_W(SET_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ctl_i.clear || ctl_i.update),
    .waddr_i(ctl_i.clear ? clr_idx_q : set_q),
    .wdata_i(ctl_i.clear ? '0 : ROW_W'(new_row)),
    .re_i   (ctl_i.rd),
    .raddr_i(set_c),
    .rdata_o(rd_data)
  );

  assign row = rd_data;

  always_comb begin
    hit_c     = 1'b0;
    inv_c     = 1'b0;
    hit_idx_c = '0;
    inv_idx_c = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if ((5'(w) < ways) && row[w].vld && (row[w].tag == tag_q)) begin
        hit_c     = 1'b1;
        hit_idx_c = WAY_W'(w);
      end
      if ((5'(w) < ways) && !row[w].vld) begin
        inv_c     = 1'b1;
        inv_idx_c = WAY_W'(w);
      end
    end
    vic_idx_c = '0;
    best_age  = row[0].age;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if ((5'(w) < ways) && (row[w].age > best_age)) begin
        vic_idx_c = WAY_W'(w);
        best_age  = row[w].age;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.look) begin
      hit_q     <= hit_c;
      inv_q     <= inv_c;
      hit_idx_q <= hit_idx_c;
      inv_idx_q <= inv_idx_c;
      vic_idx_q <= vic_idx_c;
    end
  end

  always_comb begin
    w_sel = hit_q ? hit_idx_q : (inv_q ? inv_idx_q : vic_idx_q);
    limit = hit_q ? {1'b0, row[w_sel].age} : AGE_LIM;
    new_row = row;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if ((5'(i) < ways) && (WAY_W'(i) != w_sel) && row[i].vld &&
          ({1'b0, row[i].age} < limit) && (row[i].age < AGE_MAX)) begin
        new_row[i].age = row[i].age + AGE_W'(1);
      end
    end
    new_row[w_sel].age = '0;
    if (!hit_q) begin
      new_row[w_sel].vld = 1'b1;
      new_row[w_sel].tag = tag_q;
    end
  end

  always_comb begin
    hits_d  = hits_q;
    miss_d  = miss_q;
    evict_d = evict_q;
    if (hit_q) begin
      outcome_c = OUT_HIT;
      if (hits_q != '1) hits_d = hits_q + CNT_W'(1);
    end else begin
      outcome_c = inv_q ? OUT_MISS : OUT_EVICT;
      if (miss_q != '1) miss_d = miss_q + CNT_W'(1);
      if (!inv_q && (evict_q != '1)) evict_d = evict_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q      <= '0;
      miss_q      <= '0;
      evict_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.update) begin
        hits_q      <= hits_d;
        miss_q      <= miss_d;
        evict_q     <= evict_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.update) begin
      outcome_q <= outcome_c;
      last_q    <= ctl_i.last;
    end
  end

  assign sts_o.clr_last  = (clr_idx_q == SET_W'(NUM_SETS - 1));
  assign sts_o.is_modify = is_modify_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_outcome_o = outcome_q;
  assign out_last_o    = last_q;
  assign out_hits_o    = hits_q;
  assign out_misses_o  = miss_q;
  assign out_evicts_o  = evict_q;

  a_update_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
      ctl_i.update |-> (!out_valid_q || out_ready_i))
    else $error("result slot overwritten while still held");

  a_evict_le_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_q |-> (evict_q <= miss_q))
    else $error("eviction total exceeds miss total");

  a_totals_change_on_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !ctl_i.update |=> $stable({hits_q, miss_q, evict_q}))
    else $error("running totals changed outside an update");

  a_clear_excl_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
      ctl_i.clear |-> !(ctl_i.update || ctl_i.rd || ctl_i.capture))
    else $error("access started during the clearing pass");

endmodule
